// ===== design/sysres_pkg.sv =====
// Shared types and constants for the systematic resampler.
// Used by sysres_ctrl, sysres_dp and systematic_resampler_core; depends on nothing.
`default_nettype none

package sysres_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int WEIGHT_BITS_DEF   = 16;

	// Port field widths.
	localparam int WEIGHT_W = 16;
	localparam int OFFSET_W = 16;
	localparam int INDEX_W  = 6;

	// The start offset is a fraction of one in units of 2^-FRAC_BITS.
	localparam int FRAC_BITS = 16;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_ACCUM = 5'b00100,
		ST_TEST  = 5'b01000,
		ST_ZERO  = 5'b10000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // store the incoming weight
		logic run_init;   // start the selection pass at particle zero
		logic accum;      // add the current weight times n to the left side
		logic step;       // move on to the next particle
		logic emit_hit;   // emit the current particle index
		logic emit_zero;  // emit the zero-total result
		logic clear;      // end of run, start a new set
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic total_zero; // stored weights sum to zero
		logic hit;        // current particle covers the next sample point
		logic last_k;     // the next index emitted is the final one
		logic slot_free;  // output register can take an item this cycle
	} stat_t;

endpackage

`default_nettype wire

// ===== design/systematic_resampler_core.sv =====
// Top level of the systematic resampler: controller plus datapath.
// Depends on sysres_pkg, sysres_ctrl and sysres_dp.
`default_nettype none

// Systematic (low-variance) resampling for a particle filter. Weights come in one
// item per cycle while loading; the item with is_last set closes the set, and the
// offset taken with the first weight of the set is the random start fraction
// u/65536. The block then delivers exactly n particle indices, n being the number
// of stored weights. A set whose weights sum to zero gives a single item with
// zero_total set, and weights beyond MAX_PARTICLES are dropped and flag overflow
// on every item of the run. The selection pass starts with the registered read of
// the first weight, multiply-accumulates the weight of each particle and tests it
// against the sample points in turn: each point the particle covers emits its
// index, and a point it does not cover steps the pass past the particle with a
// read of the next weight. No new weight is taken while a run is in progress, but
// the next set may start loading while the final index still waits in the output
// register.

module systematic_resampler_core #(
	parameter int MAX_PARTICLES = sysres_pkg::MAX_PARTICLES_DEF,
	parameter int WEIGHT_BITS   = sysres_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [sysres_pkg::WEIGHT_W-1:0] weight,
	input  wire logic [sysres_pkg::OFFSET_W-1:0] offset,
	input  wire logic                            is_last,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [sysres_pkg::INDEX_W-1:0]  index,
	output logic                                 zero_total,
	output logic                                 overflow,
	output logic                                 last_index
);

	// The controller issues one-cycle commands; the datapath answers with the
	// result of its compare and the state of the output register.
	sysres_pkg::cmd_t  cmd;
	sysres_pkg::stat_t stat;

	sysres_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath compares cum*n*65536 against (u + k*65536)*total. Both sides are
	// built up by additions: the right side starts as u times the total, summed while
	// the weights load, and grows by total*65536 with every index emitted.
	sysres_dp #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.WEIGHT_BITS   (WEIGHT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.weight     (weight),
		.offset     (offset),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.index      (index),
		.zero_total (zero_total),
		.overflow   (overflow),
		.last_index (last_index)
	);

endmodule

`default_nettype wire

// ===== design/sysres_ctrl.sv =====
// Sequencer of the systematic resampler: loads a set, then walks the particles.
// Depends on sysres_pkg for the state, command and status types.
`default_nettype none

module sysres_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              is_last,
	output logic                   in_ready,
	input  wire sysres_pkg::stat_t stat,
	output sysres_pkg::cmd_t       cmd
);

	sysres_pkg::state_t state_q;
	sysres_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sysres_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			sysres_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (is_last) begin
						state_nxt = sysres_pkg::ST_CHECK;
					end
				end
			end
			sysres_pkg::ST_CHECK: begin
				if (stat.total_zero) begin
					state_nxt = sysres_pkg::ST_ZERO;
				end else begin
					cmd.run_init = 1'b1;
					state_nxt    = sysres_pkg::ST_ACCUM;
				end
			end
			sysres_pkg::ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_nxt = sysres_pkg::ST_TEST;
			end
			sysres_pkg::ST_TEST: begin
				if (stat.hit) begin
					if (stat.slot_free) begin
						cmd.emit_hit = 1'b1;
						if (stat.last_k) begin
							cmd.clear = 1'b1;
							state_nxt = sysres_pkg::ST_LOAD;
						end
					end
				end else begin
					cmd.step  = 1'b1;
					state_nxt = sysres_pkg::ST_ACCUM;
				end
			end
			sysres_pkg::ST_ZERO: begin
				if (stat.slot_free) begin
					cmd.emit_zero = 1'b1;
					cmd.clear     = 1'b1;
					state_nxt     = sysres_pkg::ST_LOAD;
				end
			end
			default: begin
				state_nxt = sysres_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/sysres_dp.sv =====
// Datapath of the systematic resampler: weight memory, running sums and output register.
// Depends on sysres_pkg for constants and the command and status types.
`default_nettype none

module sysres_dp #(
	parameter int MAX_PARTICLES = sysres_pkg::MAX_PARTICLES_DEF,
	parameter int WEIGHT_BITS   = sysres_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sysres_pkg::cmd_t                  cmd,
	output sysres_pkg::stat_t                      stat,
	input  wire logic [sysres_pkg::WEIGHT_W-1:0]   weight,
	input  wire logic [sysres_pkg::OFFSET_W-1:0]   offset,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [sysres_pkg::INDEX_W-1:0]    index,
	output logic                                   zero_total,
	output logic                                   overflow,
	output logic                                   last_index
);

	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int IW = $clog2(MAX_PARTICLES);
	localparam int TW = WEIGHT_BITS + CW;
	localparam int AW = WEIGHT_BITS + 2 * CW;
	localparam int RW = AW + sysres_pkg::FRAC_BITS;
	localparam int PW = sysres_pkg::OFFSET_W + WEIGHT_BITS;
	localparam int CB = (WEIGHT_BITS < sysres_pkg::WEIGHT_W) ? WEIGHT_BITS
		: sysres_pkg::WEIGHT_W;

	logic [WEIGHT_BITS-1:0] mem [MAX_PARTICLES];

	logic [CW-1:0]                  count_q;
	logic [TW-1:0]                  total_q;
	logic [sysres_pkg::OFFSET_W-1:0] frac_q;
	logic                           ovf_q;
	logic [CW-1:0]                  i_q;
	logic [CW-1:0]                  k_q;
	logic [WEIGHT_BITS-1:0]         rd_q;
	logic [AW-1:0]                  accl_q;
	logic [RW-1:0]                  accr_q;
	logic                           out_valid_q;
	logic [sysres_pkg::INDEX_W-1:0] index_q;
	logic                           zero_q;
	logic                           ovf_out_q;
	logic                           last_q;

	logic [WEIGHT_BITS-1:0]          w_eff;
	logic [sysres_pkg::OFFSET_W-1:0] frac_sel;
	logic                            store_ok;
	logic [CW-1:0]                   i_next;
	logic [IW-1:0]                   rd_addr;

	assign w_eff    = WEIGHT_BITS'(weight[CB-1:0]);
	assign frac_sel = (count_q == '0 && !ovf_q) ? offset : frac_q;
	assign store_ok = count_q < CW'(MAX_PARTICLES);
	assign i_next   = cmd.run_init ? '0 : i_q + CW'(1);
	assign rd_addr  = i_next[IW-1:0];

	always_comb begin
		stat.total_zero = (total_q == '0);
		stat.hit        = {accl_q, {sysres_pkg::FRAC_BITS{1'b0}}} > accr_q;
		stat.last_k     = (k_q + CW'(1)) == count_q;
		stat.slot_free  = !out_valid_q || out_ready;
	end

	// Weight store: one write port during loading, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) begin
			mem[count_q[IW-1:0]] <= w_eff;
		end
		if (cmd.run_init || cmd.step) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			frac_q  <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			k_q     <= '0;
			accl_q  <= '0;
			accr_q  <= '0;
		end else begin
			if (cmd.load) begin
				frac_q <= frac_sel;
				if (store_ok) begin
					total_q <= total_q + TW'(w_eff);
					count_q <= count_q + CW'(1);
					accr_q  <= accr_q + RW'(PW'(frac_sel) * PW'(w_eff));
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.run_init) begin
				i_q    <= '0;
				k_q    <= '0;
				accl_q <= '0;
			end
			if (cmd.step) begin
				i_q <= i_next;
			end
			if (cmd.accum) begin
				accl_q <= accl_q + AW'(rd_q) * AW'(count_q);
			end
			if (cmd.emit_hit) begin
				k_q <= k_q + CW'(1);
				if (!cmd.clear) begin
					accr_q <= accr_q + RW'({total_q, {sysres_pkg::FRAC_BITS{1'b0}}});
				end
			end
			if (cmd.clear) begin
				count_q <= '0;
				total_q <= '0;
				ovf_q   <= 1'b0;
				accr_q  <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_hit || cmd.emit_zero) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hit || cmd.emit_zero) begin
			index_q   <= cmd.emit_zero ? '0 : sysres_pkg::INDEX_W'(i_q);
			zero_q    <= cmd.emit_zero;
			ovf_out_q <= ovf_q;
			last_q    <= cmd.emit_zero || stat.last_k;
		end
	end

	assign out_valid  = out_valid_q;
	assign index      = index_q;
	assign zero_total = zero_q;
	assign overflow   = ovf_out_q;
	assign last_index = last_q;

endmodule

`default_nettype wire

// ===== dv/systematic_resampler_core_tb.sv =====
// Self-checking testbench for systematic_resampler_core: directed table, then random sets.
// Depends on sysres_pkg and the resampler RTL; predicts every index on its own.
`default_nettype none

module systematic_resampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXP        = sysres_pkg::MAX_PARTICLES_DEF;
	localparam int WB          = sysres_pkg::WEIGHT_BITS_DEF;
	localparam int WEIGHT_W    = sysres_pkg::WEIGHT_W;
	localparam int OFFSET_W    = sysres_pkg::OFFSET_W;
	localparam int INDEX_W     = sysres_pkg::INDEX_W;
	localparam int FRAC_BITS   = sysres_pkg::FRAC_BITS;
	localparam int NUM_DIR     = 22;
	localparam int RAND_ITEMS  = 200;
	// Time to watch for stray items once every owed item has arrived.
	localparam int DRAIN       = 4 * MAXP + 40;
	localparam int CYCLE_LIMIT = 400000;

	// One surviving-particle item as it leaves the block.
	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               zero_total;
		logic               overflow;
		logic               last_index;
	} pick_t;

	// One row of the directed table. Where typed is set, want is the single item the
	// row must produce, written down by hand; other rows go through the predictor.
	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [OFFSET_W-1:0] offset;
		logic                is_last;
		logic                typed;
		pick_t               want;
	} dir_row_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [WEIGHT_W-1:0] weight     = '0;
	logic [OFFSET_W-1:0] offset     = '0;
	logic                is_last    = 1'b0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [INDEX_W-1:0]  index;
	logic                zero_total;
	logic                overflow;
	logic                last_index;

	// Items still owed by the block, oldest first.
	pick_t pick_q[$];
	int    errors = 0;
	int    cycles = 0;

	// Idling switches, flipped per set so there are stretches without any gaps.
	bit tx_idle_en = 1'b0;
	bit rx_stall_en = 1'b0;
	int stall_left = 0;

	// Predictor state: a private copy of the weight store and the set bookkeeping.
	logic [WEIGHT_W-1:0] wstore [MAXP];
	longint unsigned     wsum = 0;
	int unsigned         nloaded = 0;
	logic [OFFSET_W-1:0] start_frac = '0;
	bit                  ovf_seen = 1'b0;

	dir_row_t dir_rows [NUM_DIR];

	systematic_resampler_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.weight     (weight),
		.offset     (offset),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.index      (index),
		.zero_total (zero_total),
		.overflow   (overflow),
		.last_index (last_index)
	);

	always #5 clk = ~clk;

	// Watchdog. A hang anywhere, including an item the block never delivers, ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Consumer side. Ready is lowered for random stretches, mostly short, now and
	// then long; a stretch starts only while rx_stall_en is set.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
			                                         : $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Output checker. Values are sampled at the edge, before the block's own
	// updates land, so the handshake seen here is the one the block saw.
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pick_q.size() == 0) begin
				$error("unexpected item: index %0d zero_total %0b overflow %0b last_index %0b",
				       index, zero_total, overflow, last_index);
				errors++;
			end else begin
				want = pick_q.pop_front();
				if (index !== want.index) begin
					$error("index: expected %0d, got %0d", want.index, index);
					errors++;
				end
				if (zero_total !== want.zero_total) begin
					$error("zero_total: expected %0b, got %0b", want.zero_total, zero_total);
					errors++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					errors++;
				end
				if (last_index !== want.last_index) begin
					$error("last_index: expected %0b, got %0b", want.last_index, last_index);
					errors++;
				end
			end
		end
	end

	// Appends one owed item at the tail of the queue.
	function automatic void owe_pick(input pick_t p);
		pick_q.insert(pick_q.size(), p);
	endfunction

	// Takes one accepted weight item, queues the indices it releases and returns
	// how many. A particle is picked again and again while its running sum, scaled
	// by n and by 2^16, still exceeds (start + k * 2^16) times the total.
	function automatic int resample_predict(input logic [WEIGHT_W-1:0] w,
	                                         input logic [OFFSET_W-1:0] off,
	                                         input bit last);
		longint unsigned wmask;
		longint unsigned n;
		longint unsigned cum;
		longint unsigned k;
		longint unsigned fone;
		int              cnt;
		pick_t           p;
		wmask = (64'd1 << WB) - 1;
		fone  = 64'd1 << FRAC_BITS;
		cnt   = 0;
		// The offset is only taken with the first weight of a set.
		if (nloaded == 0 && !ovf_seen)
			start_frac = off;
		if (nloaded < MAXP) begin
			wstore[nloaded] = WEIGHT_W'(w & wmask);
			wsum += w & wmask;
			nloaded++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (!last)
			return 0;
		n = nloaded;
		if (wsum == 0) begin
			p = '{index: '0, zero_total: 1'b1, overflow: ovf_seen, last_index: 1'b1};
			owe_pick(p);
			cnt = 1;
		end else begin
			cum = 0;
			k   = 0;
			for (int i = 0; i < nloaded; i++) begin
				cum += wstore[i];
				while (k < n && cum * n * fone > (longint'(start_frac) + k * fone) * wsum) begin
					k++;
					p = '{index: i[INDEX_W-1:0], zero_total: 1'b0, overflow: ovf_seen,
					      last_index: (k == n)};
					owe_pick(p);
					cnt++;
				end
			end
		end
		wsum     = 0;
		nloaded  = 0;
		ovf_seen = 1'b0;
		return cnt;
	endfunction

	// Idle cycles ahead of the next weight: mostly none, some short, a few long.
	function automatic int tx_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!tx_idle_en || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [WEIGHT_W-1:0] draw_weight(input int mode);
		case (mode)
			0: return '0;
			1: return ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom_range(0, 65535)) : '0;
			2: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return WEIGHT_W'(1);
				endcase
			end
			default: return WEIGHT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Presents one weight item and holds it until the block takes it. Called
	// right after a rising edge; returns at the edge where the item was accepted.
	task automatic send_weight(input logic [WEIGHT_W-1:0] w,
	                           input logic [OFFSET_W-1:0] off,
	                           input bit last);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		weight   <= w;
		offset   <= off;
		is_last  <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin
		int               cnt;
		int               rand_items;
		int               rand_picks;
		int               set_no;
		int               set_len;
		int               wmode;
		logic [OFFSET_W-1:0] first_off;
		logic [WEIGHT_W-1:0] w;

		// Directed table. The first rows are single-weight sets and all-zero sets whose
		// one item is plain; the rest cover the largest offset, an offset on a later
		// weight that must be ignored, equal weights, leading zero weights and
		// alternating bit patterns.
		dir_rows = '{
			'{16'd100,   16'd0,     1'b1, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}},
			'{16'd0,     16'd0,     1'b1, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}},
			'{16'd65535, 16'd65535, 1'b1, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}},
			'{16'd0,     16'd0,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd0,     16'd65535, 1'b1, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}},
			'{16'd65535, 16'd0,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd0,     16'd0,     1'b1, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd1,     16'd65535, 1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd1,     16'd0,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd65535, 16'd0,     1'b1, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd10,    16'd0,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd10,    16'd65535, 1'b1, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd1000,  16'd32768, 1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd1000,  16'd0,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd1000,  16'd0,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd1000,  16'd0,     1'b1, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd0,     16'd1,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd0,     16'd0,     1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd7,     16'd0,     1'b1, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd43690, 16'd21845, 1'b0, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd21845, 16'd43690, 1'b1, 1'b0, '{6'd0, 1'b0, 1'b0, 1'b0}},
			'{16'd1,     16'd0,     1'b1, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}}
		};

		// Hold reset, then release it on an edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, with both sides idling.
		tx_idle_en  = 1'b1;
		rx_stall_en = 1'b1;
		for (int r = 0; r < NUM_DIR; r++) begin
			send_weight(dir_rows[r].weight, dir_rows[r].offset, dir_rows[r].is_last);
			cnt = resample_predict(dir_rows[r].weight, dir_rows[r].offset,
			                       dir_rows[r].is_last);
			// Hand-written rows replace what the predictor queued for them.
			if (dir_rows[r].typed) begin
				repeat (cnt) void'(pick_q.pop_back());
				owe_pick(dir_rows[r].want);
			end
		end

		// Random part: whole sets with random content. Most sets are small, some run
		// up to the capacity, and sets two and five go past it to raise overflow.
		rand_items = 0;
		rand_picks = 0;
		set_no     = 0;
		while (rand_items < RAND_ITEMS || rand_picks < 48) begin
			tx_idle_en  = ($urandom_range(0, 3) != 0);
			rx_stall_en = ($urandom_range(0, 3) != 0);
			if (set_no == 2 || set_no == 5)
				set_len = $urandom_range(MAXP + 1, MAXP + 8);
			else if ($urandom_range(0, 9) < 7)
				set_len = $urandom_range(1, 8);
			else if ($urandom_range(0, 2) < 2)
				set_len = $urandom_range(9, 32);
			else
				set_len = $urandom_range(33, MAXP);
			wmode = $urandom_range(0, 9);
			case ($urandom_range(0, 5))
				0: first_off = '0;
				1: first_off = '1;
				default: first_off = OFFSET_W'($urandom_range(0, 65535));
			endcase
			for (int i = 0; i < set_len; i++) begin
				w = draw_weight(wmode);
				// Later weights carry random offsets, which the block must ignore.
				if (i != 0)
					first_off = OFFSET_W'($urandom_range(0, 65535));
				send_weight(w, first_off, i == set_len - 1);
				rand_picks += resample_predict(w, first_off, i == set_len - 1);
				rand_items++;
			end
			// Now and then the sender holds off until the block has caught up.
			if (set_no % 7 == 3) begin
				in_valid <= 1'b0;
				while (pick_q.size() != 0)
					@(posedge clk);
			end
			set_no++;
		end
		in_valid <= 1'b0;

		// Let every owed item arrive, then watch a while longer for strays.
		while (pick_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (errors == 0 && pick_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
